// ===== design/lrn_pkg.sv =====
// ----------------------------------------------------------------------------
// lrn_pkg: shared types and constants for the cross-channel LRN core
// Item formats, configuration record, job record and the exp2 root table.
// ----------------------------------------------------------------------------
package lrn_pkg;

  localparam int DATA_W   = 16;   // sample / normalized, Q8.8
  localparam int SQ_W     = 32;   // square of a sample, Q16.16
  localparam int SUM_W    = 36;   // running window sum
  localparam int ALPHA_W  = 32;
  localparam int BETA_W   = 16;
  localparam int WSIZE_W  = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int NROOT    = 16;   // fraction bits of the exponent

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WSIZE = 2'd2;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = 32'd858993;
  localparam logic [BETA_W-1:0]  BETA_RST  = 16'd12288;
  localparam logic [WSIZE_W-1:0] WSIZE_RST = 5'd5;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     last_channel;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] normalized;
    logic                     last_of_pixel;
  } out_item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha_div_size;
    logic [BETA_W-1:0]  beta_exponent;
    logic [WSIZE_W-1:0] window_size;
  } lrn_cfg_t;

  // one output to compute: the centre sample and the window sum seen by it
  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic [SUM_W-1:0]         sum;
    logic                     last;
  } job_t;

  typedef logic [NROOT-1:0][31:0] root_arr_t;

  function automatic logic [31:0] isqrt64(input logic [63:0] a);
    logic [63:0] v;
    logic [63:0] rr;
    logic [63:0] b;
    v  = a;
    rr = '0;
    b  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= rr + b) begin
        v  = v - (rr + b);
        rr = (rr >> 1) + b;
      end else begin
        rr = rr >> 1;
      end
      b = b >> 2;
    end
    return rr[31:0];
  endfunction

  // r[k] = 2^32 * 2^-(2^-(k+1)), each the integer root of the one before
  function automatic root_arr_t build_roots();
    root_arr_t r;
    r[0] = isqrt64(64'h8000_0000_0000_0000);
    for (int k = 1; k < NROOT; k++) begin
      r[k] = isqrt64({r[k-1], 32'h0});
    end
    return r;
  endfunction

endpackage

// ===== design/lrn_fifo.sv =====
// ----------------------------------------------------------------------------
// lrn_fifo: small register queue
// Parts the front from the back and the back from the result port.
// ----------------------------------------------------------------------------
module lrn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(do_wr) - CW'(do_rd);
    end
  end
endmodule

// ===== design/lrn_front.sv =====
// ----------------------------------------------------------------------------
// lrn_front: delay lines, running sum of squares and output scheduling
// Takes one channel per item, issues one job per output to the back.
// ----------------------------------------------------------------------------
module lrn_front #(
  parameter int MAX_WINDOW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lrn_pkg::in_item_t item,
  output logic              full,
  input  lrn_pkg::lrn_cfg_t cfg,
  output logic              job_push,
  output lrn_pkg::job_t     job,
  input  logic              job_full
);
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int MAXR  = MAX_WINDOW / 2 + 1;
  localparam int NW    = $clog2(MAXR + 1);
  localparam logic F_IDLE = 1'b0;
  localparam logic F_EMIT = 1'b1;

  logic                              state;
  logic signed [lrn_pkg::DATA_W-1:0] sdel [MAX_WINDOW];
  logic [lrn_pkg::SQ_W-1:0]          qdel [MAX_WINDOW];
  logic [lrn_pkg::SUM_W-1:0]         sum;
  logic [15:0]                       rcv;
  logic [15:0]                       emt;
  logic                              last_r;
  logic [NW-1:0]                     n_cnt;

  logic [7:0]                  wsz8;
  logic [7:0]                  ws_eff;
  logic [7:0]                  pre;
  logic [7:0]                  post;
  logic [lrn_pkg::DATA_W-1:0]  x_mag;
  logic [lrn_pkg::SQ_W-1:0]    sq;
  logic [15:0]                 pending;
  logic [15:0]                 pos;
  logic [16:0]                 old;
  logic [lrn_pkg::SQ_W-1:0]    sub;
  logic [lrn_pkg::SUM_W-1:0]   sum_sub;
  logic                        emit_ok;
  logic                        emit_go;
  logic                        accept;
  logic                        clear_all;

  // effective window: 0 acts as 1, large values clamp
  always_comb begin
    wsz8 = 8'(cfg.window_size);
    if (wsz8 == 8'd0) begin
      ws_eff = 8'd1;
    end else if (wsz8 > 8'(MAX_WINDOW)) begin
      ws_eff = 8'(MAX_WINDOW);
    end else begin
      ws_eff = wsz8;
    end
    pre  = (ws_eff - 8'd1) >> 1;
    post = ws_eff - 8'd1 - pre;
  end

  assign x_mag = item.sample[lrn_pkg::DATA_W-1] ? lrn_pkg::DATA_W'(-item.sample)
                                                : lrn_pkg::DATA_W'(item.sample);
  assign sq    = x_mag * x_mag;

  assign pending = rcv - emt;
  assign pos     = pending - 16'd1;
  assign old     = 17'(pos) + 17'(pre);
  assign sub     = (old < 17'(MAX_WINDOW)) ? qdel[old[IDX_W-1:0]] : '0;
  assign sum_sub = (sum >= lrn_pkg::SUM_W'(sub)) ? sum - lrn_pkg::SUM_W'(sub) : '0;

  assign emit_ok = (pending != 16'd0) && (n_cnt < NW'(MAXR))
                && (last_r || (pending > 16'(post)));
  assign emit_go   = (state == F_EMIT) && emit_ok && !job_full;
  assign accept    = (state == F_IDLE) && push;
  assign clear_all = rst || ((state == F_EMIT) && !emit_ok && last_r);
  assign full      = (state != F_IDLE);
  assign job_push  = emit_go;

  always_comb begin
    job.sample = (pos < 16'(MAX_WINDOW)) ? sdel[pos[IDX_W-1:0]] : '0;
    job.sum    = sum;
    job.last   = last_r && (pending == 16'd1);
  end

  always_ff @(posedge clk) begin
    if (clear_all) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        sdel[i] <= '0;
        qdel[i] <= '0;
      end
      sum <= '0;
      rcv <= '0;
      emt <= '0;
    end else if (accept) begin
      sdel[0] <= item.sample;
      qdel[0] <= sq;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        sdel[i] <= sdel[i-1];
        qdel[i] <= qdel[i-1];
      end
      sum <= sum + lrn_pkg::SUM_W'(sq);
      rcv <= rcv + 16'd1;
    end else if (emit_go) begin
      sum <= sum_sub;
      emt <= emt + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      last_r <= 1'b0;
      n_cnt  <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push) begin
            last_r <= item.last_channel;
            n_cnt  <= '0;
            state  <= F_EMIT;
          end
        end
        F_EMIT: begin
          if (emit_ok) begin
            if (!job_full) begin
              n_cnt <= n_cnt + 1'b1;
              if (!last_r) begin
                state <= F_IDLE;
              end
            end
          end else begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule

// ===== design/lrn_back.sv =====
// ----------------------------------------------------------------------------
// lrn_back: power unit, y = x * (1 + a*sum)^-beta
// One job at a time: alpha product, normalize, log2 by squaring,
// beta product, exp2 by root table, scale, round and saturate.
// ----------------------------------------------------------------------------
module lrn_back (
  input  logic               clk,
  input  logic               rst,
  input  lrn_pkg::lrn_cfg_t  cfg,
  input  logic               job_empty,
  input  lrn_pkg::job_t      job,
  output logic               job_pop,
  input  logic               out_full,
  output logic               out_push,
  output lrn_pkg::out_item_t res
);
  localparam int M_W = 38;
  localparam lrn_pkg::root_arr_t ROOTS = lrn_pkg::build_roots();

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_ADD   = 4'd2;
  localparam logic [3:0] S_NORM  = 4'd3;
  localparam logic [3:0] S_LOG   = 4'd4;
  localparam logic [3:0] S_Q     = 4'd5;
  localparam logic [3:0] S_EXP   = 4'd6;
  localparam logic [3:0] S_SCALE = 4'd7;
  localparam logic [3:0] S_ROUND = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]     state;
  lrn_pkg::job_t  job_r;
  logic [51:0]    prod_hi;
  logic [47:0]    prod_lo;
  logic [M_W-1:0] m;
  logic [5:0]     expn;
  logic [15:0]    frac;
  logic [3:0]     it;
  logic [22:0]    qreg;
  logic [15:0]    qsh;
  logic [30:0]    p;
  logic [46:0]    v;
  logic [17:0]    magr;

  logic [52:0]    acc;
  logic [61:0]    msq;
  logic [31:0]    mm;
  logic [20:0]    lg;
  logic [36:0]    qfull;
  logic [62:0]    pprod;
  logic [15:0]    x_mag;
  logic [7:0]     sh;
  logic [63:0]    rnd;
  logic [17:0]    magc;
  logic [15:0]    y;

  assign acc   = 53'(prod_hi) + 53'(prod_lo[47:16]);
  assign msq   = m[30:0] * m[30:0];
  assign mm    = msq[61:30];
  assign lg    = {5'(expn - 6'd16), frac};
  assign qfull = lg * cfg.beta_exponent;
  assign pprod = p * ROOTS[it];
  assign x_mag = job_r.sample[15] ? 16'(-job_r.sample) : 16'(job_r.sample);
  assign sh    = 8'(qreg[22:16]) + 8'd30;
  assign rnd   = (64'(v) + (64'd1 << (sh - 8'd1))) >> sh;

  // saturation to the signed output range
  always_comb begin
    if (job_r.sample[15]) begin
      magc = (magr > 18'd32768) ? 18'd32768 : magr;
      y    = 16'(~magc + 18'd1);
    end else begin
      y = (magr > 18'd32767) ? 16'h7FFF : magr[15:0];
      magc = magr;
    end
  end

  assign job_pop           = (state == S_IDLE) && !job_empty;
  assign out_push          = (state == S_OUT) && !out_full;
  assign res.normalized    = y;
  assign res.last_of_pixel = job_r.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (!job_empty) begin
          state <= S_MUL;
        end
        S_MUL:   state <= S_ADD;
        S_ADD:   state <= S_NORM;
        S_NORM:  if (!(|m[M_W-1:31]) && m[30]) begin
          state <= S_LOG;
        end
        S_LOG:   if (it == 4'd15) begin
          state <= S_Q;
        end
        S_Q:     state <= S_EXP;
        S_EXP:   if (it == 4'd15) begin
          state <= S_SCALE;
        end
        S_SCALE: state <= S_ROUND;
        S_ROUND: state <= S_OUT;
        S_OUT:   if (!out_full) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        job_r <= job;
      end
      S_MUL: begin
        prod_hi <= cfg.alpha_div_size * job_r.sum[35:16];
        prod_lo <= cfg.alpha_div_size * job_r.sum[15:0];
      end
      S_ADD: begin
        m    <= M_W'(acc[52:16]) + M_W'(32'h1_0000);
        expn <= 6'd30;
      end
      S_NORM: begin
        // bring the leading one to bit 30
        if (|m[M_W-1:31]) begin
          m    <= m >> 1;
          expn <= expn + 6'd1;
        end else if (!m[30]) begin
          m    <= m << 1;
          expn <= expn - 6'd1;
        end else begin
          frac <= '0;
          it   <= '0;
        end
      end
      S_LOG: begin
        if (mm[31]) begin
          m    <= M_W'(mm >> 1);
          frac <= {frac[14:0], 1'b1};
        end else begin
          m    <= M_W'(mm);
          frac <= {frac[14:0], 1'b0};
        end
        it <= it + 4'd1;
      end
      S_Q: begin
        qreg <= qfull[36:14];
        qsh  <= qfull[29:14];
        p    <= 31'h4000_0000;
        it   <= '0;
      end
      S_EXP: begin
        if (qsh[15]) begin
          p <= pprod[62:32];
        end
        qsh <= qsh << 1;
        it  <= it + 4'd1;
      end
      S_SCALE: begin
        v <= x_mag * p;
      end
      S_ROUND: begin
        magr <= (sh > 8'd62) ? '0 : rnd[17:0];
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOG) |-> (expn >= 6'd16 && expn <= 6'd40))
    else $error("log2 exponent out of range");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result written into a full queue");

  a_pop_start: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> (state == S_MUL))
    else $error("job taken without starting the power unit");
endmodule

// ===== design/local_response_norm_across_channels_core.sv =====
// ----------------------------------------------------------------------------
// local_response_norm_across_channels_core: cross-channel LRN
// Channels of a pixel stream in one per item; each output is
// x * (1 + alpha_div_size * sum)^-beta over a centered window.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  -----------------------------
//  input    in         push / full           item   (sample, last_channel)
//  result   out        pop / empty           result (normalized, last_of_pixel)
//  config   in         cfg_valid / cfg_ready cfg_index, cfg_data
//
//  The front takes an item while idle and then issues the job that has
//  become due, if any, stalling while the job queue is full. On the last
//  channel it flushes the remaining outputs, then clears the pixel state.
//  The back's power unit works on one job at a time and sets the sustained
//  rate (up to 14 normalize shifts, 16 log2 squarings, 16 exp2 products).
//  Reset clears the delay lines, sum, counters and queues.
//  The two sides stall on their own through a 2-entry job queue and a
//  2-entry result queue; full is high whenever the front is not idle.
//
module local_response_norm_across_channels_core #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  lrn_pkg::in_item_t                  item,
  output logic                               empty,
  input  logic                               pop,
  output lrn_pkg::out_item_t                 result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lrn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lrn_pkg::CFG_DATA_W-1:0]     cfg_data
);
  localparam int JOB_W = $bits(lrn_pkg::job_t);
  localparam int RES_W = $bits(lrn_pkg::out_item_t);

  lrn_pkg::lrn_cfg_t  cfg;
  lrn_pkg::job_t      job_in;
  lrn_pkg::job_t      job_out;
  lrn_pkg::out_item_t res_in;
  logic [JOB_W-1:0]   job_q;
  logic [RES_W-1:0]   res_q;
  logic               job_push;
  logic               job_full;
  logic               job_pop;
  logic               job_empty;
  logic               out_push;
  logic               out_full;

  // configuration registers; always ready, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha_div_size <= lrn_pkg::ALPHA_RST;
      cfg.beta_exponent  <= lrn_pkg::BETA_RST;
      cfg.window_size    <= lrn_pkg::WSIZE_RST;
    end else if (cfg_valid) begin
      priority case (cfg_index)
        lrn_pkg::CFG_ALPHA: cfg.alpha_div_size <= cfg_data;
        lrn_pkg::CFG_BETA:  cfg.beta_exponent  <= cfg_data[lrn_pkg::BETA_W-1:0];
        lrn_pkg::CFG_WSIZE: cfg.window_size    <= cfg_data[lrn_pkg::WSIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: window bookkeeping and scheduling of outputs
  lrn_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cfg      (cfg),
    .job_push (job_push),
    .job      (job_in),
    .job_full (job_full)
  );

  lrn_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (job_push),
    .din   (job_in),
    .full  (job_full),
    .rd    (job_pop),
    .dout  (job_q),
    .empty (job_empty)
  );

  assign job_out = lrn_pkg::job_t'(job_q);

  // back: power computation
  lrn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .res       (res_in)
  );

  lrn_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (out_push),
    .din   (res_in),
    .full  (out_full),
    .rd    (pop),
    .dout  (res_q),
    .empty (empty)
  );

  assign result = lrn_pkg::out_item_t'(res_q);
endmodule

// ===== sim/lrn_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lrn_checker: scoreboard for the cross-channel LRN core
// Watches the config, input and result channels, predicts every result
// and compares each popped result field by field with the oldest one due.
// ----------------------------------------------------------------------------
module lrn_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic                           full,
  input  lrn_pkg::in_item_t              item,
  input  logic                           empty,
  input  logic                           pop,
  input  lrn_pkg::out_item_t             result,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lrn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrn_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             outstanding
);
  import lrn_pkg::*;

  localparam int WMAX = 16;
  localparam longint unsigned SUM_MASK = 64'hF_FFFF_FFFF;

  logic [ALPHA_W-1:0]  alpha_q;
  logic [BETA_W-1:0]   beta_q;
  logic [WSIZE_W-1:0]  wsize_q;

  logic signed [DATA_W-1:0] x_line [WMAX];
  longint unsigned          sq_line [WMAX];
  longint unsigned          wsum;
  logic [15:0]              n_in;
  logic [15:0]              n_out;

  longint unsigned exp_roots [16];
  out_item_t       due_q [$];

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // log2 of a Q16.16 value >= 1.0, Q.16, by repeated squaring
  function automatic longint unsigned log2_q16(longint unsigned s);
    int p;
    longint unsigned m, frac;
    p = 63;
    frac = 0;
    while (p > 0 && ((s >> p) & 64'd1) == 0) p--;
    if (p < 16) return 0;
    m = (p >= 30) ? (s >> (p - 30)) : (s << (30 - p));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 64'd1;
        m = m >> 1;
      end
    end
    return (longint'(p - 16) << 16) | frac;
  endfunction

  function automatic logic [DATA_W-1:0] lrn_scale(logic signed [DATA_W-1:0] x,
                                                  longint unsigned sum);
    longint unsigned a, t, q, qi, qf, pr, v, sh, mag, ax;
    longint signed y;
    a  = alpha_q;
    t  = (a * (sum >> 16) + ((a * (sum & 64'hFFFF)) >> 16)) >> 16;
    q  = (log2_q16(64'd65536 + t) * beta_q) >> 14;
    qi = q >> 16;
    qf = q & 64'hFFFF;
    pr = 64'd1 << 30;
    for (int k = 0; k < 16; k++)
      if (((qf >> (15 - k)) & 64'd1) != 0) pr = (pr * exp_roots[k]) >> 32;
    ax  = (x < 0) ? longint'(-longint'(x)) : longint'(x);
    v   = ax * pr;
    sh  = 30 + qi;
    mag = (sh > 62) ? 0 : ((v + (64'd1 << (sh - 1))) >> sh);
    if (mag > 32768) mag = 32768;
    y = (x < 0) ? -longint'(mag) : longint'(mag);
    if (y > 32767) y = 32767;
    return y[DATA_W-1:0];
  endfunction

  function automatic void clear_pixel();
    for (int i = 0; i < WMAX; i++) begin
      x_line[i]  = '0;
      sq_line[i] = 0;
    end
    wsum  = 0;
    n_in  = '0;
    n_out = '0;
  endfunction

  // one accepted channel: shift, add its square, emit what is due
  function automatic void take_channel(in_item_t it);
    int unsigned ws, pre, post, pos, old;
    logic [15:0] pending;
    longint unsigned ax, sub;
    logic signed [DATA_W-1:0] xv;
    out_item_t r;
    int n;
    ws = wsize_q;
    if (ws < 1) ws = 1;
    if (ws > WMAX) ws = WMAX;
    pre  = (ws - 1) / 2;
    post = ws - 1 - pre;
    for (int i = WMAX - 1; i > 0; i--) begin
      x_line[i]  = x_line[i-1];
      sq_line[i] = sq_line[i-1];
    end
    x_line[0]  = it.sample;
    ax         = (it.sample < 0) ? longint'(-longint'(it.sample)) : longint'(it.sample);
    sq_line[0] = ax * ax;
    wsum       = (wsum + sq_line[0]) & SUM_MASK;
    n_in       = n_in + 16'd1;
    pending    = n_in - n_out;
    n = 0;
    while (pending > 0 && n < WMAX / 2 + 1 && (it.last_channel || pending > post)) begin
      pos = pending - 1;
      old = pos + pre;
      xv  = (pos < WMAX) ? x_line[pos] : '0;
      r.normalized    = lrn_scale(xv, wsum);
      r.last_of_pixel = it.last_channel && pending == 1;
      due_q.push_back(r);
      n++;
      sub  = (old < WMAX) ? sq_line[old] : 0;
      wsum = (wsum >= sub) ? wsum - sub : 0;
      n_out = n_out + 16'd1;
      pending = pending - 16'd1;
      if (!it.last_channel) break;
    end
    if (it.last_channel) clear_pixel();
  endfunction

  initial begin
    exp_roots[0] = floor_sqrt(64'd1 << 63);
    for (int k = 1; k < 16; k++) exp_roots[k] = floor_sqrt(exp_roots[k-1] << 32);
  end

  assign outstanding = due_q.size();

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      alpha_q = ALPHA_RST;
      beta_q  = BETA_RST;
      wsize_q = WSIZE_RST;
      clear_pixel();
      due_q.delete();
      errors  <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ALPHA: alpha_q = cfg_data[ALPHA_W-1:0];
          CFG_BETA:  beta_q  = cfg_data[BETA_W-1:0];
          CFG_WSIZE: wsize_q = cfg_data[WSIZE_W-1:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (due_q.size() == 0) begin
          if (errors < 10) $display("unexpected result %h", result);
          errors <= errors + 1;
        end else begin
          want = due_q.pop_front();
          if (want.normalized !== result.normalized ||
              want.last_of_pixel !== result.last_of_pixel) begin
            if (errors < 10)
              $display("bad result: want y=%h last=%b, got y=%h last=%b",
                       want.normalized, want.last_of_pixel,
                       result.normalized, result.last_of_pixel);
            errors <= errors + 1;
          end
        end
      end
      if (push && !full) take_channel(item);
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for local_response_norm_across_channels_core
// Drives pixels of channel items and config writes under varied back
// pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import lrn_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 300;

  logic clk, rst;
  logic push, full, empty, pop;
  in_item_t  item;
  out_item_t result;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int errors, outstanding;

  int send_idle_pct, recv_idle_pct;
  logic hold_req, hold_seen;
  int hold_cnt;
  int cycles;

  local_response_norm_across_channels_core i_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lrn_checker i_checker (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("local_response_norm_across_channels_core: mismatch");
      $finish;
    end
  end

  // receiver: random pops, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pop       <= 1'b0;
      hold_cnt  <= 0;
      hold_seen <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt  <= 600;
      pop       <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      pop      <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one item; push stays high afterwards unless the sender idles
  task automatic send_item(logic signed [DATA_W-1:0] s, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= '{sample: s, last_channel: last};
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_sample();
    case ($urandom_range(3))
      0:       return 16'($urandom);                  // full range
      1:       return $signed(16'($urandom_range(255))) - 16'sd128;
      2:       return $signed(16'($urandom_range(2047))) - 16'sd1024;
      default: return $urandom_range(1) ? 16'sh7fff - 16'($urandom_range(7))
                                        : 16'sh8000 + 16'($urandom_range(7));
    endcase
  endfunction

  task automatic send_pixel(int len);
    for (int i = 0; i < len; i++) send_item(rand_sample(), i == len - 1);
  endtask

  // waits for the block to go idle first: all results in, plus the DRAIN_WAIT margin
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_setup();
    int w;
    w = $urandom_range(9);
    write_reg(CFG_ALPHA, $urandom_range(1) ? $urandom : $urandom_range(4000000));
    write_reg(CFG_BETA,  $urandom_range(1) ? $urandom : ($urandom & 32'hFFFF_7FFF));
    write_reg(CFG_WSIZE, (w == 0) ? ($urandom & 32'hFFFF_FFE0) | 32'd16 :
                         ($urandom & 32'hFFFF_FFE0) | 32'($urandom_range(1, 16)));
  endtask

  task automatic random_phase(int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      // mostly real pixels, sometimes one-channel or very long ones
      case ($urandom_range(9))
        0:       len = 1;
        1:       len = $urandom_range(17, 30);
        default: len = $urandom_range(2, 12);
      endcase
      send_pixel(len);
      sent += len;
    end
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    cycles = 0;
    send_idle_pct = 11;
    recv_idle_pct = 69;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes with reset config, edges of the window
    send_item(16'sh7fff, 1'b0);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh0000, 1'b0);
    send_item(16'sh0001, 1'b0);
    send_item(-16'sh0001, 1'b0);
    send_item(16'sh0100, 1'b1);
    send_item(16'sh8000, 1'b1);          // one-channel pixel
    write_reg(CFG_WSIZE, 32'd1);
    send_item(16'sh7fff, 1'b0);
    send_item(16'sh8000, 1'b1);
    write_reg(CFG_WSIZE, 32'd0);         // acts as one
    send_item(16'sh1234, 1'b0);
    send_item(-16'sh0800, 1'b1);
    write_reg(CFG_WSIZE, 32'hFFFF_FFFF); // above the maximum: saturates
    write_reg(CFG_ALPHA, 32'hFFFF_FFFF);
    write_reg(CFG_BETA, 32'h0000_FFFF);
    send_item(16'sh7fff, 1'b0);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7fff, 1'b0);
    send_item(16'sh4000, 1'b1);          // flush of all four outputs
    write_reg(CFG_ALPHA, 32'd0);
    write_reg(CFG_BETA, 32'd0);
    write_reg(CFG_WSIZE, 32'd16);
    send_item(16'sh7fff, 1'b0);
    send_item(-16'sh7fff, 1'b1);
    // window shrinks mid-pixel: result still has to follow the running rule
    write_reg(CFG_ALPHA, 32'd858993);
    write_reg(CFG_BETA, 32'd12288);
    send_item(16'sh0300, 1'b0);
    send_item(16'sh0500, 1'b0);
    send_item(16'sh0700, 1'b0);
    write_reg(CFG_WSIZE, 32'd2);
    send_item(16'sh0900, 1'b1);

    // random, phase 1: slow receiver, with a long hold-off to fill the block
    random_setup();
    hold_req <= ~hold_req;
    random_phase(60);
    // phase 2: slow sender
    send_idle_pct = 69;
    recv_idle_pct = 11;
    random_setup();
    random_phase(60);
    // phase 3: no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_setup();
    random_phase(60);

    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("local_response_norm_across_channels_core: match");
    end else begin
      $display("local_response_norm_across_channels_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== local_response_norm_across_channels_core.f =====
design/lrn_pkg.sv
design/lrn_fifo.sv
design/lrn_front.sv
design/lrn_back.sv
design/local_response_norm_across_channels_core.sv
sim/lrn_checker.sv
sim/tb_top.sv
